### rtl/core/haversine_distance_macros.svh
// Assertion macros shared by the haversine distance RTL.
// Depends on nothing; included by the top level.
`ifndef HAVERSINE_DISTANCE_MACROS_SVH
`define HAVERSINE_DISTANCE_MACROS_SVH
`define HD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define HD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/core/hvd_pkg.sv
// Package for the haversine distance block: constants, angle table and types.
// Depends on nothing; used by haversine_distance, hvd_sincos and hvd_cordic_stage.
package hvd_pkg;
	localparam int Iters = 30;
	localparam int DataW = 40;
	localparam logic signed [DataW-1:0] QOne = 40'sd1073741824;
	localparam logic signed [DataW-1:0] CordicGain = 40'sd652032874;
	localparam logic signed [31:0] TurnMicro = 32'sd360000000;
	localparam logic signed [31:0] HalfMicro = 32'sd180000000;
	localparam logic signed [31:0] QuartMicro = 32'sd90000000;
	// The angle scale pi*2^32 equals 19190 * 703125 + 68955, and 68955 / 703125
	// reduces to 4597 / 46875. Division by 46875 uses the reciprocal ceil(2^44 / 46875).
	localparam logic [14:0] PiQuotK = 15'd19190;
	localparam logic [12:0] PiRemK = 13'd4597;
	localparam logic [15:0] DivK = 16'd46875;
	localparam logic [28:0] RecipK = 29'd375299969;
	localparam logic [24:0] TwoRM = 25'd12745600;
	localparam logic [24:0] MaxDist = 25'd20020742;
	localparam int DefaultLatency = 3;

	typedef logic signed [DataW-1:0] q_t;

	function automatic q_t atan_entry(input int i);
		q_t t;
		case (i)
			0: t = 40'sd843314856;
			1: t = 40'sd497837829;
			2: t = 40'sd263043836;
			3: t = 40'sd133525158;
			4: t = 40'sd67021686;
			5: t = 40'sd33543515;
			6: t = 40'sd16775850;
			7: t = 40'sd8388437;
			8: t = 40'sd4194282;
			9: t = 40'sd2097149;
			10: t = 40'sd1048575;
			11: t = 40'sd524287;
			12: t = 40'sd262143;
			13: t = 40'sd131071;
			14: t = 40'sd65535;
			15: t = 40'sd32767;
			16: t = 40'sd16383;
			17: t = 40'sd8191;
			18: t = 40'sd4095;
			19: t = 40'sd2047;
			20: t = 40'sd1023;
			21: t = 40'sd511;
			22: t = 40'sd255;
			23: t = 40'sd127;
			24: t = 40'sd63;
			25: t = 40'sd31;
			26: t = 40'sd15;
			27: t = 40'sd8;
			28: t = 40'sd4;
			29: t = 40'sd2;
			default: t = '0;
		endcase
		return t;
	endfunction
endpackage

### rtl/core/haversine_distance.sv
// Great-circle distance between two points given in signed microdegrees, returned in whole
// meters on a sphere of radius 6372.8 km. The block is a fixed pipeline: an item is taken at
// every edge where start is high, busy is tied low, and the result is on distance_metres with
// done high for one cycle. The delay comes from the angle conversion, two 30-stage CORDIC
// pipelines and a 31-stage square root; the receiver cannot hold results off, so nothing
// ever stalls. Depends on hvd_pkg, hvd_sincos, hvd_isqrt and hvd_cordic_stage.
`include "haversine_distance_macros.svh"
module haversine_distance #(
	parameter int Latency = hvd_pkg::DefaultLatency
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [27:0] first_latitude,
	input  logic signed [28:0] first_longitude,
	input  logic signed [27:0] second_latitude,
	input  logic signed [28:0] second_longitude,
	output logic               done,
	output logic [24:0]        distance_metres
);
	typedef hvd_pkg::q_t q_t;
	localparam int Pre = 7;
	localparam int Cor = hvd_pkg::Iters;
	localparam int Sq = 31;
	localparam int CnDly = Pre + Cor - 2;
	localparam int Total = Pre + Cor + 4 + Sq + Cor + 2 + Latency;

	assign busy = 1'b0;

	function automatic logic signed [31:0] wrap(input logic signed [31:0] d);
		logic signed [31:0] r;
		r = d;
		if (r >= hvd_pkg::HalfMicro) r = r - hvd_pkg::TurnMicro;
		else if (r < -hvd_pkg::HalfMicro) r = r + hvd_pkg::TurnMicro;
		return r;
	endfunction

	function automatic q_t mulq(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		p = p + 64'sd536870912;
		return q_t'(p >>> 30);
	endfunction

	logic [Total-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Total-2:0], start};
	end

	// s1: wrapped differences and latitudes.
	logic signed [31:0] dlat_s1, dlon_s1, l1_s1, l2_s1;
	always_ff @(posedge clk) begin
		dlat_s1 <= wrap(32'(second_latitude) - 32'(first_latitude));
		dlon_s1 <= wrap(32'(second_longitude) - 32'(first_longitude));
		l1_s1 <= 32'(first_latitude);
		l2_s1 <= 32'(second_latitude);
	end

	// s2: supplement fold, magnitudes and signs.
	logic [27:0] m_s2 [0:3];
	logic [3:0] ng_s2;
	logic [1:0] cn_s2;
	logic signed [31:0] rl1, rl2;
	logic c1, c2;
	always_comb begin
		rl1 = l1_s1; c1 = 1'b0;
		if (rl1 > hvd_pkg::QuartMicro) begin rl1 = hvd_pkg::HalfMicro - rl1; c1 = 1'b1; end
		else if (rl1 < -hvd_pkg::QuartMicro) begin
			rl1 = -hvd_pkg::HalfMicro - rl1; c1 = 1'b1;
		end
		rl2 = l2_s1; c2 = 1'b0;
		if (rl2 > hvd_pkg::QuartMicro) begin rl2 = hvd_pkg::HalfMicro - rl2; c2 = 1'b1; end
		else if (rl2 < -hvd_pkg::QuartMicro) begin
			rl2 = -hvd_pkg::HalfMicro - rl2; c2 = 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		m_s2[0] <= 28'(dlat_s1[31] ? -dlat_s1 : dlat_s1);
		m_s2[1] <= 28'(dlon_s1[31] ? -dlon_s1 : dlon_s1);
		m_s2[2] <= 28'(rl1[31] ? -rl1 : rl1);
		m_s2[3] <= 28'(rl2[31] ? -rl2 : rl2);
		ng_s2 <= {rl2[31], rl1[31], dlon_s1[31], dlat_s1[31]};
		cn_s2 <= {c2, c1};
	end

	// s3 to s7: the magnitude times pi*2^32, rounded and divided by 2^k * 703125.
	// The half differences use k = 11 and the latitudes k = 10.
	logic [56:0] qp_s3 [0:3];
	logic [27:0] mg_s3 [0:3];
	logic [12:0] u_s4 [0:3];
	logic [15:0] v_s4 [0:3];
	logic [27:0] mg_s4 [0:3];
	logic [27:0] w_s5 [0:3];
	logic [43:0] base_s5 [0:3];
	logic [56:0] tp_s6 [0:3];
	logic [43:0] base_s6 [0:3];
	logic [3:0] ng_s3, ng_s4, ng_s5, ng_s6;
	logic [43:0] fsum_v [0:3];
	logic [31:0] quo_v [0:3];
	q_t ang_s7 [0:3];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			fsum_v[k] = base_s6[k] + 44'(tp_s6[k][56:44]);
			quo_v[k] = (k < 2) ? 32'(fsum_v[k] >> 11) : 32'(fsum_v[k] >> 10);
		end
	end
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			qp_s3[k] <= m_s2[k] * hvd_pkg::RecipK;
			mg_s3[k] <= m_s2[k];
			u_s4[k] <= qp_s3[k][56:44];
			v_s4[k] <= 16'(mg_s3[k] - 28'(qp_s3[k][56:44] * hvd_pkg::DivK));
			mg_s4[k] <= mg_s3[k];
			w_s5[k] <= 28'(v_s4[k] * hvd_pkg::PiRemK);
			base_s5[k] <= 44'(mg_s4[k]) * 44'(hvd_pkg::PiQuotK)
				+ 44'(u_s4[k]) * 44'(hvd_pkg::PiRemK) + ((k < 2) ? 44'd1024 : 44'd512);
			tp_s6[k] <= w_s5[k] * hvd_pkg::RecipK;
			base_s6[k] <= base_s5[k];
			ang_s7[k] <= ng_s6[k] ? -q_t'(quo_v[k]) : q_t'(quo_v[k]);
		end
		ng_s3 <= ng_s2;
		ng_s4 <= ng_s3;
		ng_s5 <= ng_s4;
		ng_s6 <= ng_s5;
	end

	logic [1:0] cn_cq [0:CnDly];
	assign cn_cq[0] = cn_s2;
	for (genvar j = 0; j < CnDly; j++) begin : g_cn
		always_ff @(posedge clk) cn_cq[j+1] <= cn_cq[j];
	end

	q_t sn [0:3];
	q_t cs [0:3];
	for (genvar k = 0; k < 4; k++) begin : g_sc
		hvd_sincos u_sc (.clk(clk), .angle(ang_s7[k]), .sin_q(sn[k]), .cos_q(cs[k]));
	end

	// Products.
	q_t hlat_s8, hlon_s8, cc_s8, c1_v, c2_v, hlat_s9, m_s9;
	always_comb begin
		c1_v = cn_cq[CnDly][0] ? -cs[2] : cs[2];
		c2_v = cn_cq[CnDly][1] ? -cs[3] : cs[3];
	end
	always_ff @(posedge clk) begin
		hlat_s8 <= mulq(32'(sn[0]), 32'(sn[0]));
		hlon_s8 <= mulq(32'(sn[1]), 32'(sn[1]));
		cc_s8 <= mulq(32'(c1_v), 32'(c2_v));
		hlat_s9 <= hlat_s8;
		m_s9 <= mulq(32'(cc_s8), 32'(hlon_s8));
	end

	q_t a_s10;
	q_t sum_v;
	always_comb sum_v = hlat_s9 + m_s9;
	always_ff @(posedge clk) begin
		if (sum_v > hvd_pkg::QOne) a_s10 <= hvd_pkg::QOne;
		else if (sum_v[hvd_pkg::DataW-1]) a_s10 <= '0;
		else a_s10 <= sum_v;
	end

	logic [61:0] ra_s11, rb_s11;
	always_ff @(posedge clk) begin
		ra_s11 <= {a_s10[31:0], 30'd0};
		rb_s11 <= {32'(hvd_pkg::QOne - a_s10), 30'd0};
	end

	logic [30:0] sa, sb;
	hvd_isqrt #(.InW(62)) u_sqa (.clk(clk), .radicand(ra_s11), .root(sa));
	hvd_isqrt #(.InW(62)) u_sqb (.clk(clk), .radicand(rb_s11), .root(sb));

	q_t ax [0:Cor];
	q_t ay [0:Cor];
	q_t az [0:Cor];
	assign ax[0] = q_t'(sb);
	assign ay[0] = q_t'(sa);
	assign az[0] = '0;
	for (genvar i = 0; i < Cor; i++) begin : g_at
		hvd_cordic_stage #(.Shift(i)) u_st (
			.clk(clk), .vectoring(1'b1),
			.x_in(ax[i]), .y_in(ay[i]), .z_in(az[i]),
			.x_out(ax[i+1]), .y_out(ay[i+1]), .z_out(az[i+1])
		);
	end

	logic [30:0] ang_s12;
	logic [55:0] dp_s13;
	always_ff @(posedge clk) begin
		ang_s12 <= az[Cor][hvd_pkg::DataW-1] ? '0 : az[Cor][30:0];
		dp_s13 <= ang_s12 * hvd_pkg::TwoRM + 56'd536870912;
	end

	logic [25:0] dr;
	logic [24:0] dist_d [0:Latency];
	assign dr = dp_s13[55:30];
	assign dist_d[0] = (dr > 26'(hvd_pkg::MaxDist)) ? hvd_pkg::MaxDist : dr[24:0];
	for (genvar j = 0; j < Latency; j++) begin : g_out
		always_ff @(posedge clk) dist_d[j+1] <= dist_d[j];
	end
	assign distance_metres = dist_d[Latency];
	assign done = vld_q[Total-1];

	`HD_ASSERT_IMPL(a_busy_low, clk, arst_n, 1'b1, !busy, "busy asserted")
	`HD_ASSERT_NEXT(a_vld_pipe, clk, arst_n, start, vld_q[0], "start lost")
	`HD_ASSERT_IMPL(a_range, clk, arst_n, done, distance_metres <= hvd_pkg::MaxDist, "range")
endmodule

### rtl/core/hvd_cordic_stage.sv
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
// Depends on hvd_pkg.
module hvd_cordic_stage #(
	parameter int Shift = 0
) (
	input  logic             clk,
	input  logic             vectoring,
	input  hvd_pkg::q_t      x_in,
	input  hvd_pkg::q_t      y_in,
	input  hvd_pkg::q_t      z_in,
	output hvd_pkg::q_t      x_out,
	output hvd_pkg::q_t      y_out,
	output hvd_pkg::q_t      z_out
);
	hvd_pkg::q_t xs, ys, at;
	logic pos;
	always_comb begin
		xs = x_in >>> Shift;
		ys = y_in >>> Shift;
		at = hvd_pkg::atan_entry(Shift);
		pos = vectoring ? !y_in[hvd_pkg::DataW-1] : !z_in[hvd_pkg::DataW-1];
	end
	always_ff @(posedge clk) begin
		if (pos != vectoring) begin
			x_out <= x_in - ys;
			y_out <= y_in + xs;
			z_out <= z_in - at;
		end else begin
			x_out <= x_in + ys;
			y_out <= y_in - xs;
			z_out <= z_in + at;
		end
	end
endmodule

### rtl/core/hvd_sincos.sv
// Thirty-stage pipelined CORDIC for sine and cosine of a Q30 angle.
// Depends on hvd_pkg and hvd_cordic_stage.
module hvd_sincos (
	input  logic        clk,
	input  hvd_pkg::q_t angle,
	output hvd_pkg::q_t sin_q,
	output hvd_pkg::q_t cos_q
);
	hvd_pkg::q_t xv [0:hvd_pkg::Iters];
	hvd_pkg::q_t yv [0:hvd_pkg::Iters];
	hvd_pkg::q_t zv [0:hvd_pkg::Iters];
	assign xv[0] = hvd_pkg::CordicGain;
	assign yv[0] = '0;
	assign zv[0] = angle;
	for (genvar i = 0; i < hvd_pkg::Iters; i++) begin : g_st
		hvd_cordic_stage #(.Shift(i)) u_st (
			.clk(clk), .vectoring(1'b0),
			.x_in(xv[i]), .y_in(yv[i]), .z_in(zv[i]),
			.x_out(xv[i+1]), .y_out(yv[i+1]), .z_out(zv[i+1])
		);
	end
	assign sin_q = yv[hvd_pkg::Iters];
	assign cos_q = xv[hvd_pkg::Iters];
endmodule

### rtl/core/hvd_isqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
// Depends on nothing beyond its parameters.
module hvd_isqrt #(
	parameter int InW = 62
) (
	input  logic                clk,
	input  logic [InW-1:0]      radicand,
	output logic [InW/2-1:0]    root
);
	localparam int Steps = InW / 2;
	logic [InW-1:0] rem_v  [0:Steps];
	logic [InW-1:0] val_v  [0:Steps];
	logic [Steps-1:0] res_v [0:Steps];
	assign rem_v[0] = '0;
	assign val_v[0] = radicand;
	assign res_v[0] = '0;
	for (genvar i = 0; i < Steps; i++) begin : g_st
		logic [InW+1:0] rem_sh, trial;
		always_comb begin
			rem_sh = {rem_v[i], val_v[i][InW-1 -: 2]};
			trial = (InW+2)'({res_v[i], 2'b01});
		end
		always_ff @(posedge clk) begin
			val_v[i+1] <= val_v[i] << 2;
			if (rem_sh >= trial) begin
				rem_v[i+1] <= InW'(rem_sh - trial);
				res_v[i+1] <= {res_v[i][Steps-2:0], 1'b1};
			end else begin
				rem_v[i+1] <= InW'(rem_sh);
				res_v[i+1] <= {res_v[i][Steps-2:0], 1'b0};
			end
		end
	end
	assign root = res_v[Steps];
endmodule

### verif/testbench.sv
// Testbench for haversine_distance: directed table of coordinate pairs, then random items.
// Items are checked against a table value or an in-bench fixed-point haversine predictor.
// Depends on hvd_pkg and the haversine_distance RTL.
`timescale 1ns / 1ps
module testbench;
	typedef struct {
		logic signed [27:0] lat1;
		logic signed [28:0] lon1;
		logic signed [27:0] lat2;
		logic signed [28:0] lon2;
		int                 want;
	} point_pair_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [27:0] first_latitude;
	logic signed [28:0] first_longitude;
	logic signed [27:0] second_latitude;
	logic signed [28:0] second_longitude;
	logic               done;
	logic [24:0]        distance_metres;

	logic [24:0] pending_dist[$];
	bit          failed;
	point_pair_t plan[$];

	haversine_distance dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.first_latitude(first_latitude),
		.first_longitude(first_longitude),
		.second_latitude(second_latitude),
		.second_longitude(second_longitude),
		.done(done),
		.distance_metres(distance_metres)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint wrap_micro(input longint d);
		longint r;
		r = d % 64'sd360000000;
		if (r >= 64'sd180000000) r -= 64'sd360000000;
		if (r < -64'sd180000000) r += 64'sd360000000;
		return r;
	endfunction

	function automatic longint micro_to_q30(input longint micro, input longint unsigned div);
		longint unsigned mag;
		longint r;
		mag = (micro < 0) ? -micro : micro;
		r = (mag * 64'd13493037705 + div / 2) / div;
		return (micro < 0) ? -r : r;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic void rotate_sincos(input longint z, output longint s, output longint c);
		longint x, y, xs, ys;
		x = hvd_pkg::CordicGain;
		y = 0;
		for (int i = 0; i < hvd_pkg::Iters; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(hvd_pkg::atan_entry(i));
			end else begin
				x += ys; y -= xs; z += longint'(hvd_pkg::atan_entry(i));
			end
		end
		s = y;
		c = x;
	endfunction

	function automatic longint vector_angle(input longint y, input longint x);
		longint z, xs, ys;
		z = 0;
		for (int i = 0; i < hvd_pkg::Iters; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(hvd_pkg::atan_entry(i));
			end else begin
				x -= ys; y += xs; z -= longint'(hvd_pkg::atan_entry(i));
			end
		end
		return z;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint latitude_cos(input longint lat);
		longint r, s, c;
		bit neg;
		r = wrap_micro(lat);
		neg = 0;
		if (r > 64'sd90000000) begin
			r = 64'sd180000000 - r; neg = 1;
		end else if (r < -64'sd90000000) begin
			r = -64'sd180000000 - r; neg = 1;
		end
		rotate_sincos(micro_to_q30(r, 64'd720000000), s, c);
		return neg ? -c : c;
	endfunction

	function automatic longint half_sin_squared(input longint d);
		longint s, c;
		rotate_sincos(micro_to_q30(wrap_micro(d), 64'd1440000000), s, c);
		return qmul(s, s);
	endfunction

	function automatic logic [24:0] great_circle_metres(input point_pair_t p);
		longint lat1, lon1, lat2, lon2, a, ang, metres;
		longint unsigned sa, sb;
		lat1 = p.lat1;
		lon1 = p.lon1;
		lat2 = p.lat2;
		lon2 = p.lon2;
		a = half_sin_squared(lat2 - lat1) + qmul(qmul(latitude_cos(lat1),
			latitude_cos(lat2)), half_sin_squared(lon2 - lon1));
		if (a > (64'sd1 <<< 30)) a = 64'sd1 <<< 30;
		if (a < 0) a = 0;
		sa = int_sqrt(longint'(a) << 30);
		sb = int_sqrt(longint'((64'sd1 <<< 30) - a) << 30);
		ang = vector_angle(longint'(sa), longint'(sb));
		if (ang < 0) ang = 0;
		metres = (ang * 64'sd12745600 + (64'sd1 <<< 29)) >>> 30;
		if (metres > 64'sd20020742) metres = 64'sd20020742;
		return metres[24:0];
	endfunction

	function automatic point_pair_t pp(input longint a, input longint b, input longint c,
			input longint d, input int w);
		point_pair_t p;
		p.lat1 = 28'(a); p.lon1 = 29'(b); p.lat2 = 28'(c); p.lon2 = 29'(d); p.want = w;
		return p;
	endfunction

	function automatic point_pair_t random_pair();
		point_pair_t p;
		if ($urandom_range(0, 9) < 8) begin
			p.lat1 = 28'($urandom_range(0, 180000000) - 90000000);
			p.lon1 = 29'($urandom_range(0, 360000000) - 180000000);
			p.lat2 = 28'($urandom_range(0, 180000000) - 90000000);
			p.lon2 = 29'($urandom_range(0, 360000000) - 180000000);
		end else begin
			p.lat1 = 28'($urandom);
			p.lon1 = 29'($urandom);
			p.lat2 = 28'($urandom);
			p.lon2 = 29'($urandom);
		end
		p.want = -1;
		return p;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_dist.size() == 0) begin
				$error("distance_metres: unexpected result %0d", distance_metres);
				failed = 1;
			end else begin
				if (distance_metres !== pending_dist[0]) begin
					$error("distance_metres: expected %0d, actual %0d",
						pending_dist[0], distance_metres);
					failed = 1;
				end
				void'(pending_dist.pop_front());
			end
		end
	end

	initial begin
		#5_000_000;
		$display("haversine_distance: mismatch");
		$finish;
	end

	initial begin
		int gap;
		point_pair_t p;
		logic [24:0] d;
		failed = 0;
		arst_n = 1'b0;
		start = 1'b0;
		first_latitude = '0;
		first_longitude = '0;
		second_latitude = '0;
		second_longitude = '0;

		plan.insert(plan.size(), pp(0, 0, 0, 0, 0));
		plan.insert(plan.size(), pp(90000000, 180000000, 90000000, 180000000, 0));
		plan.insert(plan.size(), pp(-90000000, -180000000, -90000000, -180000000, 0));
		plan.insert(plan.size(), pp(0, 0, 0, 180000000, -1));
		plan.insert(plan.size(), pp(0, -180000000, 0, 180000000, -1));
		plan.insert(plan.size(), pp(90000000, 0, -90000000, 0, -1));
		plan.insert(plan.size(), pp(-90000000, 0, 90000000, 0, -1));
		plan.insert(plan.size(), pp(0, 0, 0, 1, -1));
		plan.insert(plan.size(), pp(0, 0, 1, 0, -1));
		plan.insert(plan.size(), pp(36120000, -86670000, 33940000, -118400000, -1));
		plan.insert(plan.size(), pp(45000000, 10000000, -45000000, -170000000, -1));
		plan.insert(plan.size(), pp(89999999, 0, -89999999, 179999999, -1));
		plan.insert(plan.size(), pp(-134217728, -268435456, 134217727, 268435455, -1));
		plan.insert(plan.size(), pp(134217727, 268435455, -134217728, -268435456, -1));
		plan.insert(plan.size(), pp(-134217728, 0, -134217728, 0, 0));
		plan.insert(plan.size(), pp(120000000, 30000000, -100000000, -30000000, -1));
		plan.insert(plan.size(), pp(0, 179999999, 0, -179999999, -1));
		plan.insert(plan.size(), pp(-1, -1, 1, 1, -1));
		plan.insert(plan.size(), pp(60000000, 90000000, 60000000, -90000000, -1));
		plan.insert(plan.size(), pp(10000000, 20000000, -10000000, -160000000, -1));
		for (int i = 0; i < 1250; i++) plan.insert(plan.size(), random_pair());

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < plan.size(); k++) begin
			p = plan[k];
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if (k == 600) gap = 0;
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if (k == 600) begin
				start <= 1'b0;
				while (pending_dist.size() != 0) @(posedge clk);
			end
			start <= 1'b1;
			first_latitude <= p.lat1;
			first_longitude <= p.lon1;
			second_latitude <= p.lat2;
			second_longitude <= p.lon2;
			@(posedge clk);
			while (busy) @(posedge clk);
			d = (p.want >= 0) ? p.want[24:0] : great_circle_metres(p);
			pending_dist.insert(pending_dist.size(), d);
		end
		start <= 1'b0;

		while (pending_dist.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (!failed) begin
			$display("haversine_distance: match");
		end else begin
			$display("haversine_distance: mismatch");
		end
		$finish;
	end
endmodule

### haversine_distance.f
+incdir+rtl/core
rtl/core/hvd_pkg.sv
rtl/core/hvd_cordic_stage.sv
rtl/core/hvd_sincos.sv
rtl/core/hvd_isqrt.sv
rtl/core/haversine_distance.sv
verif/testbench.sv
